// File: src/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants, types and helpers for the phase tensor parameter pipeline.
// ----------------------------------------------------------------------------
package ptp_pkg;

    // number formats
    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int IW           = 32;
    localparam int GUARD        = 58 - DATA_WIDTH;

    // internal widths: cordic datapath, angle (degrees q8.24), outputs
    localparam int CW  = 62;
    localparam int ZW  = 36;
    localparam int ATW = 30;
    localparam int OW  = 24;
    localparam int CLW = ZW - 8;
    localparam int SKW = ZW - 9;
    localparam int AZW = 28;
    localparam int HIW = CW - 32;

    // cordic iteration count, capped by the arctangent table
    localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // reference of 1.0 for the single argument arctangent
    localparam int ATAN_E     = FRAC_BITS + GUARD + 1;
    localparam int ATAN_SHIFT = (ATAN_E > 60) ? ATAN_E - 60 : 0;
    localparam int REF_EXP    = (ATAN_E > 60) ? 60 : ATAN_E;
    localparam logic signed [CW-1:0] ATAN_REF = CW'(1) << REF_EXP;

    // inverse cordic gain, q0.32
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

    // axis ratio divider
    localparam int QW         = 17;
    localparam int RATIO_FRAC = 16;
    localparam int DIV_LAT    = QW + 1;
    localparam logic [QW-1:0] RATIO_ONE = QW'(1) << RATIO_FRAC;

    // angle constants
    localparam logic signed [ZW-1:0]  DEG180_Q24 = ZW'(180) << 24;
    localparam logic signed [OW-1:0]  DEG90_Q16  = OW'(90 << 16);
    localparam logic signed [AZW-1:0] DEG180_Q16 = AZW'(180 << 16);
    localparam logic signed [AZW-1:0] DEG360_Q16 = AZW'(360 << 16);

    // arctangent of 2^-i in degrees, q8.24
    localparam logic [ATW-1:0] ATAN_DEG_Q24 [0:31] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115,
        30'd57,        30'd29,        30'd14,        30'd7,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [IW-1:0] tensor_xx;
        logic signed [IW-1:0] tensor_xy;
        logic signed [IW-1:0] tensor_yx;
        logic signed [IW-1:0] tensor_yy;
    } ptp_in_t;

    typedef struct packed {
        logic                 valid_res;
        logic signed [OW-1:0] phi_min;
        logic signed [OW-1:0] phi_max;
        logic signed [OW-1:0] skew_angle;
        logic [OW-1:0]        azimuth;
        logic [QW-1:0]        axis_ratio;
    } ptp_out_t;

    // cordic result: angle and unscaled x
    typedef struct packed {
        logic signed [ZW-1:0] angle;
        logic signed [CW-1:0] x;
    } ptp_vec_t;

    // gain corrected magnitude with its angle
    typedef struct packed {
        logic signed [ZW-1:0] angle;
        logic [CW-1:0]        mag;
    } ptp_mag_t;

    // pair of arctangent results
    typedef struct packed {
        logic signed [ZW-1:0] ang_min;
        logic signed [ZW-1:0] ang_max;
    } ptp_atan_t;

    // skew, azimuth and flag waiting for the arctangents
    typedef struct packed {
        logic                 valid_res;
        logic signed [OW-1:0] skew;
        logic [OW-1:0]        az;
    } ptp_side_t;

    // saturate to +-90 degrees q8.16
    function automatic logic signed [OW-1:0] clamp90(input logic signed [CLW-1:0] v);
        logic signed [CLW-1:0] hi;
        logic signed [CLW-1:0] lo;
        hi = CLW'(DEG90_Q16);
        lo = -hi;
        if (v > hi)
        begin
            return DEG90_Q16;
        end
        else if (v < lo)
        begin
            return -DEG90_Q16;
        end
        else
        begin
            return v[OW-1:0];
        end
    endfunction

endpackage

// File: src/ptp_cordic.sv
// ----------------------------------------------------------------------------
// ptp_cordic
// Pipelined vectoring cordic: one pre-rotation stage, then one stage per
// iteration. Gives the angle in degrees q8.24 and the unscaled magnitude.
// ----------------------------------------------------------------------------
module ptp_cordic
    import ptp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic                 out_valid,
    output ptp_vec_t             vec
);

    logic                 valid_reg [0:NSTEP];
    logic                 zero_reg  [0:NSTEP];
    logic signed [CW-1:0] x_reg     [0:NSTEP];
    logic signed [CW-1:0] y_reg     [0:NSTEP];
    logic signed [ZW-1:0] z_reg     [0:NSTEP];

    logic                 zero_next;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // left half plane vectors are turned by 180 degrees
    always_comb
    begin
        zero_next = (x_in == '0) && (y_in == '0);
        if (x_in[CW-1])
        begin
            x_next = -x_in;
            y_next = -y_in;
            z_next = y_in[CW-1] ? -DEG180_Q24 : DEG180_Q24;
        end
        else
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= zero_next;
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_iter
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] step_ang;
        logic signed [CW-1:0] xs_next;
        logic signed [CW-1:0] ys_next;
        logic signed [ZW-1:0] zs_next;

        always_comb
        begin
            dx       = y_reg[i] >>> i;
            dy       = x_reg[i] >>> i;
            step_ang = $signed({{(ZW-ATW){1'b0}}, ATAN_DEG_Q24[i]});
            if (!y_reg[i][CW-1])
            begin
                xs_next = x_reg[i] + dx;
                ys_next = y_reg[i] - dy;
                zs_next = z_reg[i] + step_ang;
            end
            else
            begin
                xs_next = x_reg[i] - dx;
                ys_next = y_reg[i] + dy;
                zs_next = z_reg[i] - step_ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            x_reg[i+1]    <= xs_next;
            y_reg[i+1]    <= ys_next;
            z_reg[i+1]    <= zs_next;
        end
    end

    // a zero vector reads as angle 0, magnitude 0
    assign out_valid = valid_reg[NSTEP];
    assign vec.angle = zero_reg[NSTEP] ? '0 : z_reg[NSTEP];
    assign vec.x     = zero_reg[NSTEP] ? '0 : x_reg[NSTEP];

endmodule

// File: src/ptp_gain.sv
// ----------------------------------------------------------------------------
// ptp_gain
// Removes the cordic gain: magnitude times 1/K in q0.32, split into two
// partial products, summed in the second stage.
// ----------------------------------------------------------------------------
module ptp_gain
    import ptp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  ptp_vec_t vec_in,
    output logic     out_valid,
    output ptp_mag_t mag_out
);

    logic [HIW-1:0]       hi;
    logic [31:0]          lo;
    logic [HIW+31:0]      prod_hi_next;
    logic [63:0]          prod_lo_next;
    logic [HIW+31:0]      prod_hi_reg;
    logic [31:0]          prod_lo_reg;
    logic signed [ZW-1:0] ang1_reg;
    logic signed [ZW-1:0] ang2_reg;
    logic [CW-1:0]        mag_reg;
    logic                 v1_reg;
    logic                 v2_reg;

    // partial products
    assign hi           = vec_in.x[CW-1:32];
    assign lo           = vec_in.x[31:0];
    assign prod_hi_next = {32'b0, hi} * {{HIW{1'b0}}, INV_GAIN};
    assign prod_lo_next = {32'b0, lo} * {32'b0, INV_GAIN};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next[63:32];
        ang1_reg    <= vec_in.angle;
        mag_reg     <= CW'(prod_hi_reg) + CW'(prod_lo_reg);
        ang2_reg    <= ang1_reg;
    end

    assign out_valid     = v2_reg;
    assign mag_out.angle = ang2_reg;
    assign mag_out.mag   = mag_reg;

endmodule

// File: src/ptp_divider.sv
// ----------------------------------------------------------------------------
// ptp_divider
// Pipelined restoring divider for |minor|/major, one quotient bit per stage,
// seventeen bits in q1.16.
// ----------------------------------------------------------------------------
module ptp_divider
    import ptp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] minor,
    input  logic [CW-1:0]        major,
    output logic                 out_valid,
    output logic [QW-1:0]        quo
);

    logic          valid_reg [0:QW];
    logic [CW-1:0] r_reg     [0:QW];
    logic [CW-1:0] d_reg     [0:QW];
    logic [QW-1:0] q_reg     [1:QW];

    // absolute value of the numerator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0] <= minor[CW-1] ? CW'(-minor) : CW'(minor);
        d_reg[0] <= major;
    end

    // compare and subtract, one bit each
    for (genvar j = 1; j <= QW; j++)
    begin : g_step
        logic [CW-1:0] rin;
        logic [CW-1:0] r_next;
        logic [QW-1:0] q_prev;
        logic          ge;

        if (j == 1)
        begin : g_first
            assign rin    = r_reg[0];
            assign q_prev = '0;
        end
        else
        begin : g_rest
            assign rin    = r_reg[j-1] << 1;
            assign q_prev = q_reg[j-1];
        end

        assign ge     = rin >= d_reg[j-1];
        assign r_next = ge ? rin - d_reg[j-1] : rin;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[j] <= r_next;
            d_reg[j] <= d_reg[j-1];
            q_reg[j] <= {q_prev[QW-2:0], ge};
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = q_reg[QW];

endmodule

// File: src/phase_tensor_parameters_core.sv
// ----------------------------------------------------------------------------
// phase_tensor_parameters_core
// Phase tensor to phi_min, phi_max, skew, azimuth and axis ratio, fully
// pipelined over four cordic units and a bit-per-stage divider.
//
//  channel   ports                  transfer
//  input     start, busy, tensor    rising edge with start high, busy low
//  output    done, result           one cycle with done high, no back-pressure
//
//  one tensor per clock; busy stays low
//  the result runs through the input stage and two cordic units in series,
//  with the gain multiply and major/minor stage between them, to the output register
//  asynchronous reset clears every valid bit; data registers are not reset
//  the result is never held: done marks the single cycle it is present
// ----------------------------------------------------------------------------
module phase_tensor_parameters_core
    import ptp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  ptp_in_t  tensor,
    output logic     done,
    output ptp_out_t result
);

    localparam int T_JOIN = (NSTEP + 1 > DIV_LAT) ? NSTEP + 1 : DIV_LAT;
    localparam int D_AT   = T_JOIN - (NSTEP + 1);
    localparam int D_DV   = T_JOIN - DIV_LAT;
    localparam int D_SD   = T_JOIN - 3;
    localparam int LAT    = 1 + (NSTEP + 1) + 2 + 1 + T_JOIN + 1;

    localparam logic signed [ZW-1:0] RND8  = ZW'(128);
    localparam logic signed [ZW-1:0] RND9  = ZW'(256);
    localparam logic signed [ZW:0]   RND9W = (ZW+1)'(256);

    function automatic logic signed [CW-1:0] widen(input logic signed [IW-1:0] a);
        return CW'(a);
    endfunction

    // the pipeline never stalls
    assign busy = 1'b0;

    // input stage: sums, differences and guard scaling
    logic                 s0_valid_reg;
    logic signed [CW-1:0] u_reg;
    logic signed [CW-1:0] v_reg;
    logic signed [CW-1:0] p_reg;
    logic signed [CW-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg <= (widen(tensor.tensor_xx) - widen(tensor.tensor_yy)) <<< GUARD;
        v_reg <= (widen(tensor.tensor_xy) + widen(tensor.tensor_yx)) <<< GUARD;
        p_reg <= (widen(tensor.tensor_xx) + widen(tensor.tensor_yy)) <<< GUARD;
        q_reg <= (widen(tensor.tensor_xy) - widen(tensor.tensor_yx)) <<< GUARD;
    end

    // magnitudes and angles of (u,v) and (p,q)
    logic     ca_valid;
    logic     cb_valid;
    ptp_vec_t ca_vec;
    ptp_vec_t cb_vec;
    logic     ga_valid;
    logic     gb_valid;
    ptp_mag_t ga_mag;
    ptp_mag_t gb_mag;

    ptp_cordic u_cordic_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .x_in      (u_reg),
        .y_in      (v_reg),
        .out_valid (ca_valid),
        .vec       (ca_vec)
    );

    ptp_cordic u_cordic_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .x_in      (p_reg),
        .y_in      (q_reg),
        .out_valid (cb_valid),
        .vec       (cb_vec)
    );

    ptp_gain u_gain_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ca_valid),
        .vec_in    (ca_vec),
        .out_valid (ga_valid),
        .mag_out   (ga_mag)
    );

    ptp_gain u_gain_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cb_valid),
        .vec_in    (cb_vec),
        .out_valid (gb_valid),
        .mag_out   (gb_mag)
    );

    // major, minor and angle difference
    logic                 m_valid_reg;
    logic [CW-1:0]        major_reg;
    logic signed [CW-1:0] minor_reg;
    logic signed [ZW:0]   diff_reg;
    logic signed [ZW-1:0] angb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= ga_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        major_reg <= ga_mag.mag + gb_mag.mag;
        minor_reg <= $signed(gb_mag.mag) - $signed(ga_mag.mag);
        diff_reg  <= (ZW+1)'(ga_mag.angle) - (ZW+1)'(gb_mag.angle);
        angb_reg  <= gb_mag.angle;
    end

    // arctangents of minor and major
    logic                 am_valid;
    logic                 aM_valid;
    ptp_vec_t             am_vec;
    ptp_vec_t             aM_vec;
    logic signed [CW-1:0] minor_arg;
    logic signed [CW-1:0] major_arg;

    assign minor_arg = minor_reg >>> ATAN_SHIFT;
    assign major_arg = $signed(major_reg) >>> ATAN_SHIFT;

    ptp_cordic u_cordic_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .x_in      (ATAN_REF),
        .y_in      (minor_arg),
        .out_valid (am_valid),
        .vec       (am_vec)
    );

    ptp_cordic u_cordic_max (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .x_in      (ATAN_REF),
        .y_in      (major_arg),
        .out_valid (aM_valid),
        .vec       (aM_vec)
    );

    // axis ratio
    logic          dv_valid;
    logic [QW-1:0] dv_quo;

    ptp_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid_reg),
        .minor     (minor_reg),
        .major     (major_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo)
    );

    // skew and azimuth: round to q8.16
    logic                  a1_vr_reg;
    logic signed [SKW-1:0] skew1_reg;
    logic signed [AZW-1:0] az1_reg;

    always_ff @(posedge clk)
    begin
        a1_vr_reg <= (major_reg != '0);
        skew1_reg <= SKW'((angb_reg + RND9) >>> 9);
        az1_reg   <= AZW'((diff_reg + RND9W) >>> 9) + DEG360_Q16;
    end

    // wrap into [0,180) and saturate the skew
    logic                  a2_vr_reg;
    logic signed [OW-1:0]  skew2_reg;
    logic signed [AZW-1:0] az2_reg;
    logic signed [AZW-1:0] az3;
    ptp_side_t             side_reg;

    always_ff @(posedge clk)
    begin
        a2_vr_reg <= a1_vr_reg;
        skew2_reg <= clamp90(CLW'(skew1_reg));
        az2_reg   <= (az1_reg >= DEG360_Q16) ? az1_reg - DEG360_Q16 : az1_reg;
    end

    assign az3 = (az2_reg >= DEG180_Q16) ? az2_reg - DEG180_Q16 : az2_reg;

    always_ff @(posedge clk)
    begin
        side_reg.valid_res <= a2_vr_reg;
        side_reg.skew      <= skew2_reg;
        side_reg.az        <= az3[OW-1:0];
    end

    // alignment delays in front of the output stage
    ptp_atan_t     at_in;
    ptp_atan_t     at_d;
    logic          at_valid_d;
    logic [QW-1:0] dv_quo_d;
    logic          dv_valid_d;
    ptp_side_t     side_d;

    assign at_in.ang_min = am_vec.angle;
    assign at_in.ang_max = aM_vec.angle;

    if (D_AT > 0)
    begin : g_at_dly
        ptp_atan_t at_dl_reg  [0:D_AT-1];
        logic      at_vdl_reg [0:D_AT-1];

        for (genvar k = 0; k < D_AT; k++)
        begin : g_tap
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    at_vdl_reg[k] <= 1'b0;
                end
                else
                begin
                    at_vdl_reg[k] <= (k == 0) ? am_valid : at_vdl_reg[(k > 0) ? k - 1 : 0];
                end
            end

            always_ff @(posedge clk)
            begin
                at_dl_reg[k] <= (k == 0) ? at_in : at_dl_reg[(k > 0) ? k - 1 : 0];
            end
        end

        assign at_d       = at_dl_reg[D_AT-1];
        assign at_valid_d = at_vdl_reg[D_AT-1];
    end
    else
    begin : g_at_thru
        assign at_d       = at_in;
        assign at_valid_d = am_valid;
    end

    if (D_DV > 0)
    begin : g_dv_dly
        logic [QW-1:0] dv_dl_reg  [0:D_DV-1];
        logic          dv_vdl_reg [0:D_DV-1];

        for (genvar k = 0; k < D_DV; k++)
        begin : g_tap
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vdl_reg[k] <= 1'b0;
                end
                else
                begin
                    dv_vdl_reg[k] <= (k == 0) ? dv_valid : dv_vdl_reg[(k > 0) ? k - 1 : 0];
                end
            end

            always_ff @(posedge clk)
            begin
                dv_dl_reg[k] <= (k == 0) ? dv_quo : dv_dl_reg[(k > 0) ? k - 1 : 0];
            end
        end

        assign dv_quo_d   = dv_dl_reg[D_DV-1];
        assign dv_valid_d = dv_vdl_reg[D_DV-1];
    end
    else
    begin : g_dv_thru
        assign dv_quo_d   = dv_quo;
        assign dv_valid_d = dv_valid;
    end

    if (D_SD > 0)
    begin : g_sd_dly
        ptp_side_t side_dl_reg [0:D_SD-1];

        for (genvar k = 0; k < D_SD; k++)
        begin : g_tap
            always_ff @(posedge clk)
            begin
                side_dl_reg[k] <= (k == 0) ? side_reg : side_dl_reg[(k > 0) ? k - 1 : 0];
            end
        end

        assign side_d = side_dl_reg[D_SD-1];
    end
    else
    begin : g_sd_thru
        assign side_d = side_reg;
    end

    // output stage: phase rounding, ratio limit, zero tensor gating
    ptp_out_t result_next;
    ptp_out_t result_reg;
    logic     done_reg;

    always_comb
    begin
        result_next = '0;
        if (side_d.valid_res)
        begin
            result_next.valid_res  = 1'b1;
            result_next.phi_min    = clamp90(CLW'((at_d.ang_min + RND8) >>> 8));
            result_next.phi_max    = clamp90(CLW'((at_d.ang_max + RND8) >>> 8));
            result_next.skew_angle = side_d.skew;
            result_next.azimuth    = side_d.az;
            result_next.axis_ratio = (dv_quo_d > RATIO_ONE) ? RATIO_ONE : dv_quo_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= at_valid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every result comes from a transfer a fixed latency earlier
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start & ~busy, LAT))
        else $error("result without matching input transfer");

    // both first-pass paths stay in step
    a_pair : assert property (@(posedge clk) disable iff (!rst_n)
        ga_valid == gb_valid)
        else $error("magnitude paths out of step");

    // both arctangent units stay in step
    a_atan_pair : assert property (@(posedge clk) disable iff (!rst_n)
        am_valid == aM_valid)
        else $error("arctangent paths out of step");

    // divider and arctangent paths meet at the output stage
    a_join : assert property (@(posedge clk) disable iff (!rst_n)
        at_valid_d == dv_valid_d)
        else $error("divider and arctangent misaligned");

    // zero tensor gives an all-zero result
    a_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.valid_res |-> result.phi_min == '0 && result.phi_max == '0
            && result.skew_angle == '0 && result.azimuth == '0 && result.axis_ratio == '0)
        else $error("zero tensor result not cleared");

    // azimuth wrapped and ratio limited
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.valid_res |-> result.azimuth < OW'(180 << 16)
            && result.axis_ratio <= RATIO_ONE)
        else $error("azimuth or axis ratio out of range");

endmodule
